@@ hdl/bbr_pkg.sv @@
// Shared types, codes and widths of the banded block reshape address core.
`timescale 1ns / 1ps

package bbr_pkg;

   localparam int MAX_COLUMNS_DEF = 256;
   localparam int INDEX_BITS_DEF  = 24;

   localparam int POS_W   = 24;
   localparam int ENTRY_W = 8;
   localparam int COL_W   = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LEN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERLAP      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ROW    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CONCAT_LEN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_USED_COLUMNS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LEN    = 3'd6;

   typedef enum logic {
      OP_TRANSLATE = 1'b0,
      OP_LOAD      = 1'b1
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [POS_W-1:0]     position;
      logic [ENTRY_W-1:0]   entry;
      logic [COL_W-1:0]     column;
      logic                 is_last;
   } item_type;

   // sideband through the gap-removal divider
   typedef struct packed {
      item_type    item;
      logic        fill;
      logic [25:0] x1;
   } gap_sb_type;

   // sideband through the column-remap divider
   typedef struct packed {
      item_type    item;
      logic        fill;
      logic [25:0] x2;
   } remap_sb_type;

endpackage

@@ hdl/bbr_channels.sv @@
// Request and response channel interfaces of the reshape address core.
`timescale 1ns / 1ps

interface bbr_req_if;
   logic                            valid;
   logic                            ready;
   logic [0:0]                      operation;
   logic [bbr_pkg::POS_W-1:0]       position;
   logic [bbr_pkg::ENTRY_W-1:0]     entry;
   logic [bbr_pkg::COL_W-1:0]       column;
   logic                            is_last;

   modport source (output valid, operation, position, entry, column, is_last, input ready);
   modport sink   (input valid, operation, position, entry, column, is_last, output ready);
endinterface

interface bbr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bbr_pkg::POS_W-1:0]       source_index;
   logic                            fill_zero;
   logic                            invalid;
   logic                            last_out;

   modport source (output valid, source_index, fill_zero, invalid, last_out, input ready);
   modport sink   (input valid, source_index, fill_zero, invalid, last_out, output ready);
endinterface

@@ hdl/banded_block_reshape_gather_address_core.sv @@
// Top level: gather-address generator for banded block reshaping.
// Pipeline from request beat to response beat: input register, three divider rows of
//   24, 27 and 25 cells, plus multiply, table read and output registers.
// Throughput: one beat per cycle; the whole pipeline holds when the response is stalled.
// Reset: synchronous, active high; after reset and after every csr write the core
//   holds req ready low while it recomputes start_row mod row_len.
// Table loads ride the pipeline and update the column table at the remap stage.
`timescale 1ns / 1ps

module banded_block_reshape_gather_address_core #(
   parameter int MAX_COLUMNS = bbr_pkg::MAX_COLUMNS_DEF,
   parameter int INDEX_BITS  = bbr_pkg::INDEX_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   bbr_req_if.sink                           req_if,
   bbr_rsp_if.source                         rsp_if,
   input  logic                              csr_write_en,
   input  logic [bbr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bbr_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int AW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int FB_W   = $clog2(MAX_COLUMNS + 1);
   localparam int CMP_W  = (FB_W > 9) ? FB_W : 9;
   localparam int A_SB_W = $bits(bbr_pkg::item_type);
   localparam int B_SB_W = $bits(bbr_pkg::gap_sb_type);
   localparam int C_SB_W = $bits(bbr_pkg::remap_sb_type);
   localparam logic [4:0] RF_START = 5'd17;

   // ---------------------------------------------------------------- config registers
   logic [15:0] row_len_ff, overlap_ff, start_row_ff;
   logic [23:0] concat_len_ff, block_len_ff;
   logic [8:0]  used_columns_ff;
   logic [12:0] block_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_len_ff      <= 16'd1;
         overlap_ff      <= '0;
         start_row_ff    <= '0;
         concat_len_ff   <= '0;
         used_columns_ff <= 9'd1;
         block_count_ff  <= 13'd1;
         block_len_ff    <= 24'd1;
      end else if (csr_write_en) begin
         unique case (csr_index)
            bbr_pkg::CSR_ROW_LEN:      row_len_ff      <= csr_data[15:0];
            bbr_pkg::CSR_OVERLAP:      overlap_ff      <= csr_data[15:0];
            bbr_pkg::CSR_START_ROW:    start_row_ff    <= csr_data[15:0];
            bbr_pkg::CSR_CONCAT_LEN:   concat_len_ff   <= csr_data[23:0];
            bbr_pkg::CSR_USED_COLUMNS: used_columns_ff <= csr_data[8:0];
            bbr_pkg::CSR_BLOCK_COUNT:  block_count_ff  <= csr_data[12:0];
            bbr_pkg::CSR_BLOCK_LEN:    block_len_ff    <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- derived values
   // Recomputed every cycle; settled long before the busy window closes.
   logic [15:0]        n_eff_in, n_eff_ff;
   logic [23:0]        blen_eff_in, blen_eff_ff;
   logic [16:0]        w_ff;
   logic signed [25:0] bm2d_ff;
   logic signed [26:0] v1_ff;
   logic signed [9:0]  ncolm1;
   logic               unfold_en_ff, gap_en_ff;

   assign n_eff_in    = (row_len_ff == '0) ? 16'd1 : row_len_ff;
   assign blen_eff_in = (block_len_ff == '0) ? 24'd1 : block_len_ff;
   assign ncolm1      = $signed({1'b0, used_columns_ff}) - 10'sd1;

   always_ff @(posedge clock) begin
      n_eff_ff     <= n_eff_in;
      blen_eff_ff  <= blen_eff_in;
      w_ff         <= {1'b0, n_eff_in} + {1'b0, overlap_ff};
      bm2d_ff      <= $signed({2'b0, blen_eff_in}) - $signed({9'b0, overlap_ff, 1'b0});
      v1_ff        <= $signed({3'b0, concat_len_ff})
                      + $signed({1'b0, overlap_ff}) * ncolm1;
      unfold_en_ff <= block_count_ff > 13'd1;
      gap_en_ff    <= used_columns_ff > 9'd1;
   end

   // ---------------------------------------------------------------- start_row mod row_len
   // Shift-subtract over the 16 bits of start_row; the count also gates req ready.
   logic [4:0]  rf_cnt_ff;
   logic [15:0] rf_rem_ff, rf_num_ff, rf_rem_in;
   logic [16:0] rf_trial;
   logic        rf_ge;

   assign rf_trial  = {rf_rem_ff, rf_num_ff[15]};
   assign rf_ge     = rf_trial >= {1'b0, n_eff_ff};
   assign rf_rem_in = rf_ge ? 16'(rf_trial - {1'b0, n_eff_ff}) : rf_trial[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_cnt_ff <= RF_START;
      end else if (csr_write_en) begin
         rf_cnt_ff <= RF_START;
      end else if (rf_cnt_ff == RF_START) begin
         rf_rem_ff <= '0;
         rf_num_ff <= start_row_ff;
         rf_cnt_ff <= rf_cnt_ff - 5'd1;
      end else if (rf_cnt_ff != '0) begin
         rf_rem_ff <= rf_rem_in;
         rf_num_ff <= {rf_num_ff[14:0], 1'b0};
         rf_cnt_ff <= rf_cnt_ff - 5'd1;
      end
   end

   // ---------------------------------------------------------------- handshake
   logic advance, accept, rsp_valid_ff;

   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = advance && (rf_cnt_ff == '0);
   assign accept       = req_if.valid && req_if.ready;

   // ---------------------------------------------------------------- input register
   logic               s0_valid_ff;
   bbr_pkg::item_type  s0_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_item_ff.op       <= bbr_pkg::op_type'(req_if.operation);
         s0_item_ff.position <= req_if.position;
         s0_item_ff.entry    <= req_if.entry;
         s0_item_ff.column   <= req_if.column;
         s0_item_ff.is_last  <= req_if.is_last;
      end
   end

   // ---------------------------------------------------------------- unfold: p / block_len
   logic              a_valid;
   logic [23:0]       a_quot, a_rem;
   logic [A_SB_W-1:0] a_sb;

   bbr_div #(.NUM_W(24), .DEN_W(24), .SB_W(A_SB_W)) u_div_unfold (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .den       (blen_eff_ff),
      .in_valid  (s0_valid_ff),
      .in_num    (s0_item_ff.position),
      .in_sb     (s0_item_ff),
      .out_valid (a_valid),
      .out_quot  (a_quot),
      .out_rem   (a_rem),
      .out_sb    (a_sb)
   );

   // multiply the block number by the stride
   logic               b1_valid_ff;
   bbr_pkg::item_type  b1_item_ff;
   logic [23:0]        b1_rem_ff;
   logic signed [49:0] b1_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff <= a_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b1_item_ff <= bbr_pkg::item_type'(a_sb);
         b1_rem_ff  <= a_rem;
         b1_prod_ff <= $signed({1'b0, a_quot}) * bm2d_ff;
      end
   end

   // unfolded index and its zero-fill test
   logic signed [50:0] xa;
   logic               fill_a;
   logic [25:0]        x1_in;
   logic               c0_valid_ff;
   bbr_pkg::gap_sb_type c0_sb_ff;

   assign xa     = $signed({27'd0, b1_rem_ff}) - $signed({35'd0, overlap_ff})
                   + $signed({b1_prod_ff[49], b1_prod_ff});
   assign fill_a = unfold_en_ff
                   && (xa < 0 || xa >= $signed({{24{v1_ff[26]}}, v1_ff}));
   assign x1_in  = unfold_en_ff ? xa[25:0] : {2'b0, b1_item_ff.position};

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_valid_ff <= 1'b0;
      end else if (advance) begin
         c0_valid_ff <= b1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c0_sb_ff.item <= b1_item_ff;
         c0_sb_ff.fill <= fill_a;
         c0_sb_ff.x1   <= x1_in;
      end
   end

   // ---------------------------------------------------------------- gap removal: / (n + d)
   logic              b_valid;
   logic [26:0]       b_quot;
   logic [16:0]       b_rem;
   logic [B_SB_W-1:0] b_sb;

   bbr_div #(.NUM_W(27), .DEN_W(17), .SB_W(B_SB_W)) u_div_gap (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .den       (w_ff),
      .in_valid  (c0_valid_ff),
      .in_num    ({1'b0, c0_sb_ff.x1} + {11'd0, rf_rem_ff}),
      .in_sb     (c0_sb_ff),
      .out_valid (b_valid),
      .out_quot  (b_quot),
      .out_rem   (b_rem),
      .out_sb    (b_sb)
   );

   logic                d1_valid_ff;
   bbr_pkg::gap_sb_type d1_sb_ff;
   logic [16:0]         d1_rem_ff;
   logic [26:0]         d1_prod_ff;
   logic [42:0]         d1_prod_in;

   // J * n never exceeds the dividend, so the low bits suffice
   assign d1_prod_in = b_quot * n_eff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff <= 1'b0;
      end else if (advance) begin
         d1_valid_ff <= b_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d1_sb_ff   <= bbr_pkg::gap_sb_type'(b_sb);
         d1_rem_ff  <= b_rem;
         d1_prod_ff <= d1_prod_in[26:0];
      end
   end

   logic                  gap_fill;
   logic [27:0]           x2_sum;
   logic                  e0_valid_ff;
   bbr_pkg::remap_sb_type e0_sb_ff;

   assign gap_fill = gap_en_ff && (d1_rem_ff >= {1'b0, n_eff_ff});
   assign x2_sum   = {11'd0, d1_rem_ff} + {1'b0, d1_prod_ff} - {12'd0, rf_rem_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         e0_valid_ff <= 1'b0;
      end else if (advance) begin
         e0_valid_ff <= d1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e0_sb_ff.item <= d1_sb_ff.item;
         e0_sb_ff.fill <= d1_sb_ff.fill || gap_fill;
         e0_sb_ff.x2   <= gap_en_ff ? x2_sum[25:0] : d1_sb_ff.x1;
      end
   end

   // ---------------------------------------------------------------- column remap: / n
   logic              f_valid;
   logic [24:0]       f_quot;
   logic [15:0]       f_rem;
   logic [C_SB_W-1:0] f_sb_vec;
   logic [26:0]       c_num;

   assign c_num = {1'b0, e0_sb_ff.x2} + {11'd0, rf_rem_ff};

   bbr_div #(.NUM_W(25), .DEN_W(16), .SB_W(C_SB_W)) u_div_remap (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .den       (n_eff_ff),
      .in_valid  (e0_valid_ff),
      .in_num    (c_num[24:0]),
      .in_sb     (e0_sb_ff),
      .out_valid (f_valid),
      .out_quot  (f_quot),
      .out_rem   (f_rem),
      .out_sb    (f_sb_vec)
   );

   // Table stage: loads write here, translates read here, so order holds.
   bbr_pkg::remap_sb_type f_sb;
   logic [15:0]           map_mem [0:MAX_COLUMNS-1];
   logic [15:0]           mem_rd_ff;
   logic [15:0]           map_base_ff;
   logic [FB_W-1:0]       first_break_ff;
   logic                  remap_en, col_bad, remap_inv, load_ok;

   assign f_sb      = bbr_pkg::remap_sb_type'(f_sb_vec);
   assign remap_en  = CMP_W'(first_break_ff) < CMP_W'(used_columns_ff);
   assign col_bad   = (f_quot >= {16'd0, used_columns_ff})
                      || (32'(f_quot) >= 32'(MAX_COLUMNS));
   assign remap_inv = remap_en && ((f_sb.x2 >= {2'b0, concat_len_ff}) || col_bad);
   assign load_ok   = advance && f_valid && (f_sb.item.op == bbr_pkg::OP_LOAD)
                      && (32'(f_sb.item.entry) < 32'(MAX_COLUMNS));

   always_ff @(posedge clock) begin
      if (load_ok) begin
         map_mem[AW'(f_sb.item.entry)] <= f_sb.item.column;
      end
      if (advance) begin
         mem_rd_ff <= map_mem[f_quot[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_base_ff    <= '0;
         first_break_ff <= FB_W'(MAX_COLUMNS);
      end else if (load_ok) begin
         if (f_sb.item.entry == '0) begin
            map_base_ff    <= f_sb.item.column;
            first_break_ff <= FB_W'(MAX_COLUMNS);
         end else if (({1'b0, f_sb.item.column} != ({1'b0, map_base_ff} + 17'(f_sb.item.entry)))
                      && (32'(f_sb.item.entry) < 32'(first_break_ff))) begin
            first_break_ff <= FB_W'(f_sb.item.entry);
         end
      end
   end

   logic               g_valid_ff;
   bbr_pkg::item_type  g_item_ff;
   logic               g_fill_ff, g_inv_ff, g_remap_ff;
   logic [25:0]        g_x2_ff;
   logic [15:0]        g_rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (advance) begin
         g_valid_ff <= f_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         g_item_ff  <= f_sb.item;
         g_fill_ff  <= f_sb.fill;
         g_inv_ff   <= remap_inv;
         g_remap_ff <= remap_en;
         g_x2_ff    <= f_sb.x2;
         g_rem_ff   <= f_rem;
      end
   end

   // scale the mapped column by the column height
   logic               h_valid_ff;
   bbr_pkg::item_type  h_item_ff;
   logic               h_fill_ff, h_inv_ff, h_remap_ff;
   logic [25:0]        h_x2_ff;
   logic [15:0]        h_rem_ff;
   logic [31:0]        h_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (advance) begin
         h_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         h_item_ff  <= g_item_ff;
         h_fill_ff  <= g_fill_ff;
         h_inv_ff   <= g_inv_ff;
         h_remap_ff <= g_remap_ff;
         h_x2_ff    <= g_x2_ff;
         h_rem_ff   <= g_rem_ff;
         h_prod_ff  <= mem_rd_ff * n_eff_ff;
      end
   end

   // ---------------------------------------------------------------- final index and output
   logic signed [33:0] x3;
   logic               range_bad, inv_in;
   logic [23:0]        src_ff;
   logic               fill_ff, inv_ff, last_ff;

   assign x3 = h_remap_ff
               ? ($signed({18'd0, h_rem_ff}) - $signed({18'd0, rf_rem_ff})
                  + $signed({2'b0, h_prod_ff}))
               : $signed({8'd0, h_x2_ff});
   assign range_bad = (x3 < 0) || (x3 >= $signed(34'd1 << INDEX_BITS));
   assign inv_in    = !h_fill_ff && (h_inv_ff || range_bad);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         // drop table loads: they produce no beat
         rsp_valid_ff <= h_valid_ff && (h_item_ff.op == bbr_pkg::OP_TRANSLATE);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         src_ff  <= (h_fill_ff || inv_in) ? '0 : x3[23:0];
         fill_ff <= h_fill_ff;
         inv_ff  <= inv_in;
         last_ff <= h_item_ff.is_last;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.source_index = src_ff;
   assign rsp_if.fill_zero    = fill_ff;
   assign rsp_if.invalid      = inv_ff;
   assign rsp_if.last_out     = last_ff;

endmodule

@@ hdl/bbr_div_cell.sv @@
// One restoring-division cell: resolves one quotient bit and hands on.
`timescale 1ns / 1ps

module bbr_div_cell #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 24,
   parameter int SB_W  = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [DEN_W-1:0] den,
   input  logic             in_valid,
   input  logic [DEN_W-1:0] in_rem,
   input  logic [NUM_W-1:0] in_qn,
   input  logic [SB_W-1:0]  in_sb,
   output logic             out_valid,
   output logic [DEN_W-1:0] out_rem,
   output logic [NUM_W-1:0] out_qn,
   output logic [SB_W-1:0]  out_sb
);

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;
   logic [DEN_W-1:0] rem_in;
   logic             valid_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] qn_ff;
   logic [SB_W-1:0]  sb_ff;

   // qn holds the unconsumed dividend bits on top and the quotient below
   assign trial  = {in_rem, in_qn[NUM_W-1]};
   assign diff   = trial - {1'b0, den};
   assign ge     = trial >= {1'b0, den};
   assign rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         qn_ff  <= {in_qn[NUM_W-2:0], ge};
         sb_ff  <= in_sb;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_qn    = qn_ff;
   assign out_sb    = sb_ff;

endmodule

@@ hdl/bbr_div.sv @@
// Pipelined divider: a row of division cells, one quotient bit per cell.
`timescale 1ns / 1ps

module bbr_div #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 24,
   parameter int SB_W  = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [DEN_W-1:0] den,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [SB_W-1:0]  in_sb,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quot,
   output logic [DEN_W-1:0] out_rem,
   output logic [SB_W-1:0]  out_sb
);

   logic             v  [0:NUM_W];
   logic [DEN_W-1:0] r  [0:NUM_W];
   logic [NUM_W-1:0] qn [0:NUM_W];
   logic [SB_W-1:0]  sb [0:NUM_W];

   assign v[0]  = in_valid;
   assign r[0]  = '0;
   assign qn[0] = in_num;
   assign sb[0] = in_sb;

   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      bbr_div_cell #(
         .NUM_W (NUM_W),
         .DEN_W (DEN_W),
         .SB_W  (SB_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .den       (den),
         .in_valid  (v[i]),
         .in_rem    (r[i]),
         .in_qn     (qn[i]),
         .in_sb     (sb[i]),
         .out_valid (v[i+1]),
         .out_rem   (r[i+1]),
         .out_qn    (qn[i+1]),
         .out_sb    (sb[i+1])
      );
   end

   assign out_valid = v[NUM_W];
   assign out_quot  = qn[NUM_W];
   assign out_rem   = r[NUM_W];
   assign out_sb    = sb[NUM_W];

endmodule

@@ hdl/bbr_checker.sv @@
// Port-level checks of the reshape address core, bound to the top level.
`timescale 1ns / 1ps

module bbr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_source_index,
   input logic        rsp_fill_zero,
   input logic        rsp_invalid,
   input logic        rsp_last_out
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_source_index)
         && $stable(rsp_fill_zero) && $stable(rsp_invalid) && $stable(rsp_last_out))
      else $error("stalled response beat changed");

   a_marks_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_fill_zero && rsp_invalid))
      else $error("fill and invalid both set");

   a_marked_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_fill_zero || rsp_invalid) |-> rsp_source_index == '0)
      else $error("marked beat carries a nonzero index");

   a_busy_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("request taken before start row residue settled");

endmodule

bind banded_block_reshape_gather_address_core bbr_checker u_bbr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_source_index (rsp_if.source_index),
   .rsp_fill_zero    (rsp_if.fill_zero),
   .rsp_invalid      (rsp_if.invalid),
   .rsp_last_out     (rsp_if.last_out)
);

@@ tb/sv/tb_banded_block_reshape_gather_address_core.sv @@
// Testbench of the banded block reshape gather-address core: directed and random beats.
`timescale 1ns / 1ps

module tb_banded_block_reshape_gather_address_core;

   localparam int  SETTLE_CYCLES = 100;      // beyond the pipeline depth
   localparam int  CYCLE_LIMIT   = 600000;
   localparam int  NCOLS         = bbr_pkg::MAX_COLUMNS_DEF;

   typedef struct packed {
      logic [bbr_pkg::POS_W-1:0] source_index;
      logic                      fill_zero;
      logic                      invalid;
      logic                      last_out;
   } addr_type;

   typedef struct {
      longint row_len;
      longint overlap;
      longint start_row;
      longint concat_len;
      longint used_columns;
      longint block_count;
      longint block_len;
   } shape_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                           csr_write_en = 1'b0;
   logic [bbr_pkg::CSR_IDX_W-1:0]  csr_index    = bbr_pkg::CSR_ROW_LEN;
   logic [bbr_pkg::CSR_DATA_W-1:0] csr_data     = '0;

   bbr_req_if req_ch ();
   bbr_rsp_if rsp_ch ();

   banded_block_reshape_gather_address_core u_top (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_ch),
      .rsp_if       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.operation = bbr_pkg::OP_TRANSLATE;
      req_ch.position  = '0;
      req_ch.entry     = '0;
      req_ch.column    = '0;
      req_ch.is_last   = 1'b0;
      rsp_ch.ready     = 1'b0;
   end

   always #5 clock = ~clock;

   // Shadow state of the address core
   shape_type                  shape;
   logic [bbr_pkg::COL_W-1:0]  col_table [NCOLS];
   longint                     table_base;
   longint                     break_entry;

   addr_type pending_addrs[$];
   int       errors      = 0;
   int       cycles      = 0;
   bit       steady      = 0;   // no gaps on either side while set
   int       rsp_hold    = 0;   // long receiver hold-off requested by a test

   // -----------------------------------------------------------------------
   // Predictor: apply one accepted beat to the shadow state; return 1 and the
   // expected gather address when the beat yields a response.
   // -----------------------------------------------------------------------
   function automatic bit gather_lookup(input bbr_pkg::item_type it, output addr_type res);
      longint n, d, rfirst, lconc, ncol, nblk, blen, v1, x, i, j, w, e;
      n = (shape.row_len == 0) ? 1 : shape.row_len;
      d = shape.overlap;
      rfirst = shape.start_row % n;
      lconc = shape.concat_len;
      ncol = shape.used_columns;
      nblk = shape.block_count;
      blen = (shape.block_len == 0) ? 1 : shape.block_len;
      v1 = lconc + d * (ncol - 1);
      x = it.position;
      res = '0;
      res.last_out = it.is_last;
      if (it.op == bbr_pkg::OP_LOAD) begin
         e = it.entry;
         col_table[e] = it.column;
         if (e == 0) begin
            table_base  = it.column;
            break_entry = NCOLS;
         end else if (longint'(it.column) != table_base + e && e < break_entry) begin
            break_entry = e;
         end
         return 1'b0;
      end
      // block unfolding with overlap
      if (nblk > 1) begin
         i = x % blen;
         j = x / blen;
         x = (i - d) + j * (blen - 2 * d);
         if (x < 0 || x >= v1) begin
            res.fill_zero = 1'b1;
            return 1'b1;
         end
      end
      // drop the gaps between columns
      if (ncol > 1) begin
         w = n + d;
         i = (x + rfirst) % w;
         j = (x + rfirst) / w;
         if (i >= n) begin
            res.fill_zero = 1'b1;
            return 1'b1;
         end
         x = i - rfirst + j * n;
      end
      // column remap once the table is no longer contiguous
      if (break_entry < ncol) begin
         if (x >= lconc) begin
            res.invalid = 1'b1;
            return 1'b1;
         end
         i = (x + rfirst) % n;
         j = (x + rfirst) / n;
         if (j >= ncol || j >= NCOLS) begin
            res.invalid = 1'b1;
            return 1'b1;
         end
         x = i - rfirst + longint'(col_table[j]) * n;
      end
      if (x < 0 || x >= (longint'(1) << bbr_pkg::INDEX_BITS_DEF)) begin
         res.invalid = 1'b1;
         return 1'b1;
      end
      res.source_index = x[bbr_pkg::POS_W-1:0];
      return 1'b1;
   endfunction

   // -----------------------------------------------------------------------
   // Sender: hold valid high across back-to-back beats; drop it only for a gap.
   // -----------------------------------------------------------------------
   task automatic send_beat(input bbr_pkg::item_type it);
      int       gap;
      addr_type res;
      gap = steady ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= it.op;
      req_ch.position  <= it.position;
      req_ch.entry     <= it.entry;
      req_ch.column    <= it.column;
      req_ch.is_last   <= it.is_last;
      do @(posedge clock); while (!req_ch.ready);
      if (gather_lookup(it, res))
         pending_addrs.push_back(res);
   endtask

   task automatic translate(input logic [bbr_pkg::POS_W-1:0] pos, input logic last);
      bbr_pkg::item_type it;
      it = '0;
      it.op = bbr_pkg::OP_TRANSLATE;
      it.position = pos;
      it.entry = 8'($urandom);
      it.column = 16'($urandom);
      it.is_last = last;
      send_beat(it);
   endtask

   task automatic load_entry(input logic [bbr_pkg::ENTRY_W-1:0] e,
                             input logic [bbr_pkg::COL_W-1:0] col);
      bbr_pkg::item_type it;
      it = '0;
      it.op = bbr_pkg::OP_LOAD;
      it.position = 24'($urandom);
      it.entry = e;
      it.column = col;
      it.is_last = 1'($urandom_range(0, 1));
      send_beat(it);
   endtask

   // Wait until every expected response is back, then let table loads clear the pipe.
   task automatic drain;
      req_ch.valid <= 1'b0;
      while (pending_addrs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all seven registers back to back while the core is idle.
   task automatic apply_shape(input shape_type s);
      longint vals[7];
      drain();
      vals = '{s.row_len, s.overlap, s.start_row, s.concat_len, s.used_columns,
               s.block_count, s.block_len};
      for (int k = 0; k < 7; k++) begin
         csr_write_en <= 1'b1;
         csr_index    <= k[bbr_pkg::CSR_IDX_W-1:0];
         csr_data     <= vals[k][bbr_pkg::CSR_DATA_W-1:0];
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      shape = s;
   endtask

   function automatic shape_type make_shape(longint n, longint d, longint sr, longint lc,
                                            longint nc, longint nb, longint bl);
      shape_type s;
      s.row_len = n; s.overlap = d; s.start_row = sr; s.concat_len = lc;
      s.used_columns = nc; s.block_count = nb; s.block_len = bl;
      return s;
   endfunction

   // -----------------------------------------------------------------------
   // Receiver: draw a stall per beat; honor a long hold-off when a test asks.
   // -----------------------------------------------------------------------
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (rsp_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (rsp_hold) @(posedge clock);
            rsp_hold = 0;
         end
         stall = steady ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Compare every response beat with the oldest expectation.
   always @(posedge clock) begin
      addr_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_addrs.size() == 0) begin
            $display("%0t: response beat with nothing expected: index %0h fz %0b inv %0b",
                     $time, rsp_ch.source_index, rsp_ch.fill_zero, rsp_ch.invalid);
            errors++;
         end else begin
            want = pending_addrs.pop_front();
            if (rsp_ch.source_index !== want.source_index) begin
               $display("%0t: source_index expected %0h actual %0h",
                        $time, want.source_index, rsp_ch.source_index);
               errors++;
            end
            if (rsp_ch.fill_zero !== want.fill_zero) begin
               $display("%0t: fill_zero expected %0b actual %0b",
                        $time, want.fill_zero, rsp_ch.fill_zero);
               errors++;
            end
            if (rsp_ch.invalid !== want.invalid) begin
               $display("%0t: invalid expected %0b actual %0b",
                        $time, want.invalid, rsp_ch.invalid);
               errors++;
            end
            if (rsp_ch.last_out !== want.last_out) begin
               $display("%0t: last_out expected %0b actual %0b",
                        $time, want.last_out, rsp_ch.last_out);
               errors++;
            end
         end
      end
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // -----------------------------------------------------------------------
   // Tests
   // -----------------------------------------------------------------------

   // Corner beats: identity at reset, extreme registers, each remap case.
   task automatic test_directed;
      // identity path with the reset register values
      translate('0, 1'b0);
      translate('1, 1'b1);
      // large register values: unfold gives negative x, and far positions
      apply_shape(make_shape(65535, 65535, 65534, 24'hFFFFFF, 256, 4096, 24'hFFFFFF));
      translate('0, 1'b0);
      translate(24'hFFFFFF, 1'b1);
      translate(24'h800000, 1'b0);
      // all three maps: rfirst 2, overlap 1, two blocks of 8
      apply_shape(make_shape(4, 1, 2, 10, 3, 2, 8));
      load_entry(8'd0, 16'd5);
      load_entry(8'd1, 16'd6);
      load_entry(8'd2, 16'd9);   // break at entry 2 enables the remap
      translate(24'd0, 1'b0);    // unfolds below zero: zero-fill
      translate(24'd1, 1'b0);
      translate(24'd3, 1'b0);    // lands in a column gap
      translate(24'd7, 1'b0);
      translate(24'd9, 1'b0);
      translate(24'd15, 1'b1);
      load_entry(8'd2, 16'd7);   // repair does not clear the break
      translate(24'd9, 1'b0);
      load_entry(8'd0, 16'd5);   // reloading entry 0 clears the break
      translate(24'd9, 1'b0);
      // remap row beyond the used columns
      apply_shape(make_shape(2, 0, 0, 10, 2, 1, 1));
      load_entry(8'd0, 16'd3);
      load_entry(8'd1, 16'd0);
      translate(24'd1, 1'b0);
      translate(24'd6, 1'b0);    // x below concat_len but column 3 >= 2: invalid
      translate(24'd12, 1'b1);   // x at or past concat_len: invalid
      // remapped index overflows the index width
      apply_shape(make_shape(65535, 0, 0, 131070, 2, 1, 1));
      load_entry(8'd0, 16'hFFFF);
      load_entry(8'd1, 16'd0);
      translate(24'd0, 1'b0);
      translate(24'd65535, 1'b1);
   endtask

   // One random register setting, a table load sequence and a run of translates.
   task automatic random_phase(input int beats);
      shape_type s;
      longint    v1, span, base;
      int        brk;
      s.row_len      = $urandom_range(1, 12);
      s.overlap      = $urandom_range(0, 4);
      s.start_row    = $urandom_range(0, 65534);
      s.used_columns = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 256)
                                                   : $urandom_range(1, 6);
      s.concat_len   = s.row_len * s.used_columns - $urandom_range(0, 32'(s.row_len - 1));
      s.block_count  = ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(2, 5);
      v1 = s.concat_len + s.overlap * (s.used_columns - 1);
      s.block_len = (v1 + s.block_count - 1) / s.block_count + 2 * s.overlap
                    + $urandom_range(0, 2) - 1;
      if (s.block_len < 1) s.block_len = 1;
      apply_shape(s);
      // contiguous table from a random base, broken at one random entry in some phases
      base = $urandom_range(0, 65535 - 256);
      brk  = ($urandom_range(0, 3) == 0) ? NCOLS : $urandom_range(1, 32'(s.used_columns));
      for (int e = 0; e < s.used_columns; e++)
         load_entry(8'(e), (e == brk) ? 16'($urandom) : 16'(base + e));
      span = (s.block_count > 1) ? s.block_count * s.block_len : v1 + s.row_len;
      if (span > 24'hFFFFFF) span = 24'hFFFFFF;
      for (int k = 0; k < beats; k++) begin
         if ($urandom_range(0, 9) == 0)
            load_entry(8'($urandom_range(0, 32'(s.used_columns - 1))), 16'($urandom));
         if ($urandom_range(0, 9) == 0)
            translate(24'($urandom), 1'($urandom_range(0, 1)));
         else
            translate(24'($urandom_range(0, 32'(span + 3))), k == beats - 1);
      end
   endtask

   task automatic test_random;
      for (int p = 0; p < 5; p++)
         random_phase(40);
      // a stretch with no idling on either side
      steady = 1;
      random_phase(40);
      steady = 0;
   endtask

   // Receiver holds off long enough for the pipeline to fill and stall the input.
   task automatic test_backpressure;
      apply_shape(make_shape(7, 2, 3, 30, 5, 3, 14));
      for (int e = 0; e < 5; e++)
         load_entry(8'(e), (e == 3) ? 16'd900 : 16'(40 + e));
      rsp_hold = 400;
      steady = 1;
      for (int k = 0; k < 150; k++)
         translate(24'($urandom_range(0, 45)), k == 149);
      steady = 0;
   endtask

   // Sender pauses until every response is back, then resumes on the same setting.
   task automatic test_pause;
      for (int k = 0; k < 20; k++)
         translate(24'($urandom_range(0, 45)), 1'b0);
      req_ch.valid <= 1'b0;
      while (pending_addrs.size() != 0) @(posedge clock);
      for (int k = 0; k < 20; k++)
         translate(24'($urandom_range(0, 45)), k == 19);
   endtask

   initial begin
      shape = make_shape(1, 0, 0, 0, 1, 1, 1);
      table_base  = 0;
      break_entry = NCOLS;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_pause();
      test_random();
      drain();
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
